// ----- rtl/lstoe_pkg.sv -----
`default_nettype none
package lstoe_pkg;

  localparam int CHANNEL_BITS_DEF = 16;

  // rec.709 luminance weights, q0.16, summing to one
  localparam logic [15:0] WEIGHT_RED   = 16'd13933;
  localparam logic [15:0] WEIGHT_GREEN = 16'd46871;
  localparam logic [15:0] WEIGHT_BLUE  = 16'd4732;

  localparam int LOG_FRAC = 16;
  localparam int PIVOT_W  = 16;
  localparam int EXP_W    = 15;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

  localparam logic [PIVOT_W-1:0] PIVOT_RESET    = 16'd737;
  localparam logic [EXP_W-1:0]   EXPONENT_RESET = 15'd16384;

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    x = n;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // q1.30 value of 2^(2^-i), i from 1
  function automatic logic [31:0] exp2_tap(input int i);
    logic [63:0] t;
    t = isqrt64(64'd2 << 60);
    for (int j = 1; j < LOG_FRAC + 1; j++) begin
      if (j < i) t = isqrt64(t << 30);
    end
    return t[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lstoe_if.sv -----
`default_nettype none
interface lstoe_in_if #(parameter int W = lstoe_pkg::CHANNEL_BITS_DEF);
  logic         valid;
  logic         ready;
  logic [W-1:0] red_in;
  logic [W-1:0] green_in;
  logic [W-1:0] blue_in;
  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface lstoe_out_if #(parameter int W = lstoe_pkg::CHANNEL_BITS_DEF);
  logic         valid;
  logic         ready;
  logic [W-1:0] red_out;
  logic [W-1:0] green_out;
  logic [W-1:0] blue_out;
  logic         toe_applied;
  logic         clipped;
  modport source (output valid, red_out, green_out, blue_out, toe_applied, clipped,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, toe_applied, clipped,
                output ready);
endinterface

interface lstoe_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lstoe_pkg::CFG_IDX_W-1:0]    index;
  logic [lstoe_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/luminance_shadow_toe_rgb_unit.sv -----
`default_nettype none
// Luminance-preserving shadow toe for a linear RGB pixel stream. Each beat forms
// rec.709 luminance Y; when 0 < Y < shadow_pivot all three channels are scaled
// so that luminance follows pivot*(Y/pivot)^exponent, saturating each channel
// (clipped flags it), else the pixel passes unchanged with toe_applied low.
// One pixel is accepted per clock while pix_in.ready is high; the result path
// has 39 pipeline stages plus the output register. The depth comes from the 16
// squaring stages of the log2 unit (two 31-bit squarers each, luminance and
// pivot) and the 16 multiply stages of the exp2 unit (one 32-bit multiplier
// each). A skid register behind the output lets the pipe keep taking pixels
// after the sink stalls until a result lands in it; pix_in.ready drops
// only while that skid register is full. Registers: index 0 shadow_pivot,
// index 1 shadow_exponent; write them only while no pixel is in flight.
module luminance_shadow_toe_rgb_unit #(
  parameter int CHANNEL_BITS = lstoe_pkg::CHANNEL_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  lstoe_cfg_if.sink     cfg,
  lstoe_in_if.sink      pix_in,
  lstoe_out_if.source   pix_out
);
  import lstoe_pkg::*;

  localparam int CB     = CHANNEL_BITS;
  localparam int YW_W   = CB + 16;                 // weighted luminance sum
  localparam int NORM_W = (YW_W > 32) ? YW_W : 32; // common width for both logs
  localparam int E_W    = $clog2(NORM_W);          // leading-one position
  localparam int LOG_W  = E_W + LOG_FRAC;          // log2 in q.16
  localparam int PR_W   = LOG_W + EXP_W;           // d times exponent
  localparam int S_W    = LOG_W + 3;               // signed gain exponent
  localparam int K_W    = S_W - LOG_FRAC;          // integer part of gain
  localparam int SH_W   = K_W + 1;
  localparam int V_W    = CB + 32;                 // channel times mantissa
  localparam int R_W    = CB + 40;                 // room for shift and round
  localparam int NSTEP  = LOG_FRAC;

  typedef logic [2:0][CB-1:0] chan3_t;
  typedef struct packed {
    chan3_t c;
    logic   app;
  } carry_t;

  // configuration registers, always ready
  logic [PIVOT_W-1:0] pivot;
  logic [EXP_W-1:0]   exponent;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot    <= PIVOT_RESET;
      exponent <= EXPONENT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PIVOT:    pivot    <= cfg.data[PIVOT_W-1:0];
        REG_EXPONENT: exponent <= cfg.data[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe advances while the skid register is free
  logic skid_v;
  logic ce;
  assign ce           = ~skid_v;
  assign pix_in.ready = ce;

  function automatic logic [E_W-1:0] lead_one(input logic [NORM_W-1:0] x);
    logic [E_W-1:0] e;
    e = '0;
    for (int i = 0; i < NORM_W; i++) begin
      if (x[i]) e = E_W'(i);
    end
    return e;
  endfunction

  // mantissa in q1.30, truncated
  function automatic logic [30:0] norm_q30(input logic [NORM_W-1:0] x,
                                           input logic [E_W-1:0] e);
    logic [NORM_W+29:0] w;
    w = {x, 30'b0} >> e;
    return w[30:0];
  endfunction

  // stage 1: luminance partial products
  logic                 s1_v;
  chan3_t               s1_c;
  logic [2:0][YW_W-1:0] s1_pr;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (ce) s1_v <= pix_in.valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_c[0]  <= pix_in.red_in;
      s1_c[1]  <= pix_in.green_in;
      s1_c[2]  <= pix_in.blue_in;
      s1_pr[0] <= YW_W'(pix_in.red_in) * YW_W'(WEIGHT_RED);
      s1_pr[1] <= YW_W'(pix_in.green_in) * YW_W'(WEIGHT_GREEN);
      s1_pr[2] <= YW_W'(pix_in.blue_in) * YW_W'(WEIGHT_BLUE);
    end
  end

  // stage 2: luminance sum and toe window test
  logic              s2_v;
  carry_t            s2_k;
  logic [YW_W-1:0]   s2_yw;
  logic [YW_W-1:0]   yw_sum;
  logic [NORM_W-1:0] pivot_w;

  assign yw_sum  = s1_pr[0] + s1_pr[1] + s1_pr[2];
  assign pivot_w = NORM_W'({pivot, 16'h0000});

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (ce) s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_k.c   <= s1_c;
      s2_k.app <= (yw_sum != '0) && (NORM_W'(yw_sum) < pivot_w);
      s2_yw    <= yw_sum;
    end
  end

  // stage 3 and 16 squaring stages: log2 of luminance and of pivot
  logic             sq_v  [NSTEP+1];
  carry_t           sq_k  [NSTEP+1];
  logic [E_W-1:0]   sq_ey [NSTEP+1];
  logic [E_W-1:0]   sq_ep [NSTEP+1];
  logic [30:0]      sq_my [NSTEP+1];
  logic [30:0]      sq_mp [NSTEP+1];
  logic [15:0]      sq_fy [NSTEP+1];
  logic [15:0]      sq_fp [NSTEP+1];
  logic [E_W-1:0]   ey_c;
  logic [E_W-1:0]   ep_c;

  assign ey_c = lead_one(NORM_W'(s2_yw));
  assign ep_c = lead_one(pivot_w);

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (ce) sq_v[0] <= s2_v;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sq_k[0]  <= s2_k;
      sq_ey[0] <= ey_c;
      sq_ep[0] <= ep_c;
      sq_my[0] <= norm_q30(NORM_W'(s2_yw), ey_c);
      sq_mp[0] <= norm_q30(pivot_w, ep_c);
      sq_fy[0] <= '0;
      sq_fp[0] <= '0;
    end
  end

  for (genvar g = 0; g < NSTEP; g++) begin : g_sq
    logic [61:0] py;
    logic [61:0] pp;
    logic [31:0] qy;
    logic [31:0] qp;

    assign py = 62'(sq_my[g]) * 62'(sq_my[g]);
    assign pp = 62'(sq_mp[g]) * 62'(sq_mp[g]);
    assign qy = py[61:30];
    assign qp = pp[61:30];

    always_ff @(posedge clk) begin
      if (rst) sq_v[g+1] <= 1'b0;
      else if (ce) sq_v[g+1] <= sq_v[g];
    end

    // a square at or above two sets the next fraction bit and renormalizes
    always_ff @(posedge clk) begin
      if (ce) begin
        sq_k[g+1]  <= sq_k[g];
        sq_ey[g+1] <= sq_ey[g];
        sq_ep[g+1] <= sq_ep[g];
        sq_my[g+1] <= qy[31] ? qy[31:1] : qy[30:0];
        sq_mp[g+1] <= qp[31] ? qp[31:1] : qp[30:0];
        sq_fy[g+1] <= {sq_fy[g][14:0], qy[31]};
        sq_fp[g+1] <= {sq_fp[g][14:0], qp[31]};
      end
    end
  end

  // log distance and its product with the exponent
  logic             d_v;
  carry_t           d_k;
  logic [LOG_W-1:0] d_d;
  logic [PR_W-1:0]  d_pr;
  logic [LOG_W-1:0] log_gap;

  assign log_gap = {sq_ep[NSTEP], sq_fp[NSTEP]} - {sq_ey[NSTEP], sq_fy[NSTEP]};

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (ce) d_v <= sq_v[NSTEP];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d_k  <= sq_k[NSTEP];
      d_d  <= log_gap;
      d_pr <= PR_W'(log_gap) * PR_W'(exponent);
    end
  end

  // gain exponent d - round(d*exp), split into floor integer and fraction
  logic                   ex_v [NSTEP+1];
  carry_t                 ex_k [NSTEP+1];
  logic signed [K_W-1:0]  ex_i [NSTEP+1];
  logic [15:0]            ex_f [NSTEP+1];
  logic [31:0]            ex_m [NSTEP+1];
  logic [PR_W:0]          dp_rnd;
  logic [S_W-1:0]         s_val;

  assign dp_rnd = (PR_W+1)'(d_pr) + (PR_W+1)'(8192);
  assign s_val  = S_W'(d_d) - S_W'(dp_rnd >> 14);

  always_ff @(posedge clk) begin
    if (rst) ex_v[0] <= 1'b0;
    else if (ce) ex_v[0] <= d_v;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ex_k[0] <= d_k;
      ex_i[0] <= s_val[S_W-1:LOG_FRAC];
      ex_f[0] <= s_val[LOG_FRAC-1:0];
      ex_m[0] <= 32'h4000_0000;
    end
  end

  for (genvar g = 0; g < NSTEP; g++) begin : g_exp
    localparam logic [31:0] TAP = exp2_tap(g + 1);
    logic [63:0] prod;
    logic [63:0] rnd;

    assign prod = 64'(ex_m[g]) * 64'(TAP);
    assign rnd  = prod + 64'h2000_0000;

    always_ff @(posedge clk) begin
      if (rst) ex_v[g+1] <= 1'b0;
      else if (ce) ex_v[g+1] <= ex_v[g];
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        ex_k[g+1] <= ex_k[g];
        ex_i[g+1] <= ex_i[g];
        ex_f[g+1] <= ex_f[g];
        ex_m[g+1] <= ex_f[g][NSTEP-1-g] ? rnd[61:30] : ex_m[g];
      end
    end
  end

  // channel times mantissa
  logic                  v_v;
  carry_t                v_k;
  logic signed [K_W-1:0] v_i;
  logic [2:0][V_W-1:0]   v_p;

  always_ff @(posedge clk) begin
    if (rst) v_v <= 1'b0;
    else if (ce) v_v <= ex_v[NSTEP];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      v_k <= ex_k[NSTEP];
      v_i <= ex_i[NSTEP];
      for (int j = 0; j < 3; j++) begin
        v_p[j] <= V_W'(ex_k[NSTEP].c[j]) * V_W'(ex_m[NSTEP]);
      end
    end
  end

  // binary point shift by k-30, round half up, saturate
  logic signed [SH_W-1:0] sh;
  logic [SH_W-1:0]        rs;
  logic [2:0][R_W-1:0]    rr;
  chan3_t                 r_chan;
  logic [2:0]             r_sat;

  assign sh = SH_W'(v_i) - SH_W'(30);
  assign rs = SH_W'(-sh);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (!sh[SH_W-1]) begin
        if (sh > 8) rr[j] = (v_p[j] != '0) ? (R_W'(1) << CB) : '0;
        else rr[j] = R_W'(v_p[j]) << sh[3:0];
      end else begin
        rr[j] = (R_W'(v_p[j]) + (R_W'(1) << (rs - 1'b1))) >> rs;
      end
      r_sat[j]  = |rr[j][R_W-1:CB];
      r_chan[j] = r_sat[j] ? {CB{1'b1}} : rr[j][CB-1:0];
    end
  end

  logic   r_v;
  chan3_t r_c;
  logic   r_app;
  logic   r_clip;

  always_ff @(posedge clk) begin
    if (rst) r_v <= 1'b0;
    else if (ce) r_v <= v_v;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      r_app  <= v_k.app;
      r_clip <= v_k.app & (|r_sat);
      r_c    <= v_k.app ? r_chan : v_k.c;
    end
  end

  // output register with skid behind it
  logic   out_v;
  chan3_t out_c;
  logic   out_app;
  logic   out_clip;
  chan3_t skid_c;
  logic   skid_app;
  logic   skid_clip;
  logic   pipe_fire;

  assign pipe_fire = ce & r_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (pipe_fire) begin
      if (out_v && !pix_out.ready) skid_v <= 1'b1;
      else out_v <= 1'b1;
    end else if (pix_out.ready) begin
      if (skid_v) skid_v <= 1'b0;
      else out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_fire) begin
      if (out_v && !pix_out.ready) begin
        skid_c    <= r_c;
        skid_app  <= r_app;
        skid_clip <= r_clip;
      end else begin
        out_c    <= r_c;
        out_app  <= r_app;
        out_clip <= r_clip;
      end
    end else if (pix_out.ready && skid_v) begin
      out_c    <= skid_c;
      out_app  <= skid_app;
      out_clip <= skid_clip;
    end
  end

  assign pix_out.valid       = out_v;
  assign pix_out.red_out     = out_c[0];
  assign pix_out.green_out   = out_c[1];
  assign pix_out.blue_out    = out_c[2];
  assign pix_out.toe_applied = out_app;
  assign pix_out.clipped     = out_clip;

endmodule
`default_nettype wire

// ----- rtl/lstoe_checker.sv -----
`default_nettype none
module lstoe_checker #(
  parameter int CHANNEL_BITS = lstoe_pkg::CHANNEL_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CHANNEL_BITS-1:0] red_out,
  input logic [CHANNEL_BITS-1:0] green_out,
  input logic [CHANNEL_BITS-1:0] blue_out,
  input logic                    toe_applied,
  input logic                    clipped
);

  // stalled beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({red_out, green_out, blue_out, toe_applied, clipped}))
    else $error("stalled output beat changed");

  // saturation only happens on the toe path
  a_clip_app: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> toe_applied)
    else $error("clipped without toe");

  // input backpressure only while a result waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("output valid after reset");

endmodule

bind luminance_shadow_toe_rgb_unit lstoe_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (pix_in.ready),
  .out_valid   (pix_out.valid),
  .out_ready   (pix_out.ready),
  .red_out     (pix_out.red_out),
  .green_out   (pix_out.green_out),
  .blue_out    (pix_out.blue_out),
  .toe_applied (pix_out.toe_applied),
  .clipped     (pix_out.clipped)
);
`default_nettype wire

// ----- verif/tb_lstoe_sb.sv -----
`timescale 1ns / 1ps
// expected-pixel store and toe predictor
class toe_scoreboard;
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        toe;
    logic        clip;
  } pixel_t;

  logic [15:0] pivot;
  logic [14:0] expo;
  pixel_t      pending[$];
  int          errors;

  function new();
    pivot  = lstoe_pkg::PIVOT_RESET;
    expo   = lstoe_pkg::EXPONENT_RESET;
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] value);
    if (idx == lstoe_pkg::REG_PIVOT) pivot = value;
    else if (idx == lstoe_pkg::REG_EXPONENT) expo = value[14:0];
  endfunction

  static function longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2 in q.16 by repeated squaring of the q1.30 mantissa
  static function longint unsigned log2_fix(longint unsigned x);
    int              e;
    longint unsigned m, frac;
    e = 0;
    frac = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    m = (e > 30) ? (x >> (e - 30)) : (x << (30 - e));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    return (longint'(e) << 16) | frac;
  endfunction

  static function longint unsigned exp2_frac(longint unsigned f);
    longint unsigned t, m;
    t = int_sqrt(64'd2 << 60);
    m = 64'd1 << 30;
    for (int i = 1; i <= 16; i++) begin
      if ((f >> (16 - i)) & 1) m = (m * t + (64'd1 << 29)) >> 30;
      t = int_sqrt(t << 30);
    end
    return m;
  endfunction

  function void note_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    longint unsigned ch[3], lum, piv, dlog, dscaled, gain, v, res;
    longint          s, k, sh;
    longint unsigned f;
    pixel_t          px;
    ch[0] = 64'(r);
    ch[1] = 64'(g);
    ch[2] = 64'(b);
    px = '0;
    lum = ch[0] * 13933 + ch[1] * 46871 + ch[2] * 4732;
    piv = longint'(pivot) << 16;
    if (lum > 0 && lum < piv) begin
      px.toe = 1'b1;
      dlog = log2_fix(piv) - log2_fix(lum);
      dscaled = (dlog * expo + 8192) >> 14;
      s = longint'(dlog) - longint'(dscaled);
      // floor split into integer shift and fraction
      k = s >>> 16;
      f = s & 64'hFFFF;
      gain = exp2_frac(f);
      for (int j = 0; j < 3; j++) begin
        v = ch[j] * gain;
        sh = k - 30;
        if (sh >= 0) begin
          res = (sh > 8) ? ((v != 0) ? 64'h10000 : 64'd0) : (v << sh);
        end else begin
          if (-sh > 63) sh = -63;
          res = (v + (64'd1 << (-sh - 1))) >> (-sh);
        end
        if (res > 64'hFFFF) begin
          res = 64'hFFFF;
          px.clip = 1'b1;
        end
        ch[j] = res;
      end
    end
    px.red = ch[0][15:0];
    px.green = ch[1][15:0];
    px.blue = ch[2][15:0];
    pending.push_back(px);
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("error: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic check_pixel(pixel_t got);
    pixel_t want;
    if (pending.size() == 0) begin
      report("unexpected pixel red", got.red, 0);
      return;
    end
    want = pending.pop_front();
    if (got.red != want.red) report("red_out", got.red, want.red);
    if (got.green != want.green) report("green_out", got.green, want.green);
    if (got.blue != want.blue) report("blue_out", got.blue, want.blue);
    if (got.toe != want.toe) report("toe_applied", got.toe, want.toe);
    if (got.clip != want.clip) report("clipped", got.clip, want.clip);
  endtask
endclass

// ----- verif/tb_luminance_shadow_toe_rgb_unit.sv -----
`timescale 1ns / 1ps
module tb_luminance_shadow_toe_rgb_unit;
  import lstoe_pkg::*;

  localparam int LATENCY = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  lstoe_cfg_if cfg ();
  lstoe_in_if pix_in ();
  lstoe_out_if pix_out ();

  luminance_shadow_toe_rgb_unit dut (
    .clk(clk), .rst(rst), .cfg(cfg), .pix_in(pix_in), .pix_out(pix_out)
  );

  toe_scoreboard sb = new();

  // sink-side control
  bit no_idle;      // final part of the run: no stalls at all
  bit hold_sink;    // long hold-off requested by the stimulus
  int idle_beats;
  int quiet_cycles;

  initial begin
    cfg.valid = 1'b0;
    cfg.index = REG_PIVOT;
    cfg.data = '0;
    pix_in.valid = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_out.ready = 1'b0;
  end

  // receiver: random stall bursts, checks every accepted beat
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_out.valid && pix_out.ready)
        sb.check_pixel({pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                        pix_out.toe_applied, pix_out.clipped});
      if (hold_sink) begin
        pix_out.ready <= 1'b0;
      end else if (idle_beats > 0) begin
        idle_beats <= idle_beats - 1;
        pix_out.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        idle_beats <= int'($urandom_range(0, 10));
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
        || (cfg.valid && cfg.ready) || hold_sink) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("luminance_shadow_toe_rgb_unit: mismatch");
        $finish;
      end
    end
  end

  // one write beat, then the channel goes idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, value);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // offer one pixel, optionally after a random gap
  task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.red_in <= r;
    pix_in.green_in <= g;
    pix_in.blue_in <= b;
    do @(posedge clk); while (!pix_in.ready);
    sb.note_pixel(r, g, b);
  endtask

  task automatic drain();
    pix_in.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // random pixel, mostly dark enough to land in the toe region
  task automatic random_pixel();
    logic [15:0] r, g, b;
    int kind, top;
    kind = int'($urandom_range(0, 9));
    if (kind < 6) begin
      top = 1 << $urandom_range(0, 13);
      r = 16'($urandom_range(0, top));
      g = 16'($urandom_range(0, top));
      b = 16'($urandom_range(0, top));
    end else begin
      r = 16'($urandom);
      g = 16'($urandom);
      b = 16'($urandom);
    end
    send_pixel(r, g, b);
  endtask

  task automatic random_config();
    int pick;
    pick = int'($urandom_range(0, 4));
    case (pick)
      0: write_reg(REG_PIVOT, 16'($urandom_range(1, 65535)));
      1: write_reg(REG_PIVOT, 16'(1 << $urandom_range(0, 15)));
      default: write_reg(REG_PIVOT, 16'($urandom_range(1, 4096)));
    endcase
    // occasionally an out-of-range exponent, zero included
    if ($urandom_range(0, 7) == 0) write_reg(REG_EXPONENT, 16'($urandom_range(0, 32767)));
    else write_reg(REG_EXPONENT, 16'($urandom_range(4915, 22118)));
  endtask

  initial begin
    no_idle = 1'b0;
    hold_sink = 1'b0;
    idle_beats = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, field extremes and the special cases
    send_pixel(16'd0, 16'd0, 16'd0);          // zero luminance
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);  // far above pivot
    send_pixel(16'd737, 16'd737, 16'd737);    // luminance at pivot
    send_pixel(16'd736, 16'd736, 16'd736);    // just below pivot
    send_pixel(16'd1, 16'd0, 16'd0);
    send_pixel(16'd0, 16'd0, 16'd1);
    send_pixel(16'd0, 16'd1, 16'd0);
    send_pixel(16'd2000, 16'd0, 16'd0);       // red-only, low luminance
    send_pixel(16'd0, 16'd0, 16'hFFFF);       // full-scale blue, above pivot
    drain();
    write_reg(REG_EXPONENT, 16'd4915);        // shallow toe, channels boosted
    write_reg(REG_PIVOT, 16'hFFFF);
    send_pixel(16'd0, 16'd0, 16'hFFFF);
    send_pixel(16'd1, 16'd1, 16'd1);
    send_pixel(16'hFFFF, 16'd0, 16'd0);
    send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
    drain();
    write_reg(REG_EXPONENT, 16'd22118);
    write_reg(REG_PIVOT, 16'd1);              // smallest nonzero pivot
    send_pixel(16'd0, 16'd0, 16'd1);
    send_pixel(16'h5555, 16'hAAAA, 16'h5555);
    drain();
    write_reg(REG_EXPONENT, 16'd0);           // flat curve
    write_reg(REG_PIVOT, 16'd4096);
    send_pixel(16'd3, 16'd2, 16'd1);
    send_pixel(16'd0, 16'd0, 16'd40);
    drain();
    write_reg(REG_EXPONENT, 16'h7FFF);
    send_pixel(16'd100, 16'd50, 16'd25);
    drain();

    // long sink hold-off while pixels keep coming, so the input stalls
    hold_sink = 1'b1;
    fork
      repeat (120) random_pixel();
      begin
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end
    join
    drain();

    // random phases with fresh settings
    for (int phase = 0; phase < 10; phase++) begin
      random_config();
      if (phase == 9) no_idle = 1'b1;
      repeat (190) random_pixel();
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("luminance_shadow_toe_rgb_unit: match");
    else
      $display("luminance_shadow_toe_rgb_unit: mismatch");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/lstoe_pkg.sv
rtl/lstoe_if.sv
rtl/luminance_shadow_toe_rgb_unit.sv
rtl/lstoe_checker.sv
verif/tb_lstoe_sb.sv
verif/tb_luminance_shadow_toe_rgb_unit.sv
